// File: hdl/bcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot command byte decoder package
// Types, command codes and register indexes shared by the decoder files.
// ----------------------------------------------------------------------------
package bcbd_pkg;

    localparam int MAX_ENTRIES  = 4;
    localparam int NUM_LEN_REGS = 4;
    localparam int LEN_IDX_W    = $clog2(NUM_LEN_REGS);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [7:0] CMD_ARM_LOADER = 8'hC0;
    localparam logic [7:0] CMD_ARM_ENTRY1 = 8'hC1;
    localparam logic [7:0] CMD_PREFIX     = 8'h78;
    localparam logic [7:0] CMD_REQUEST    = 8'h22;
    localparam logic [7:0] CMD_GO_LOADER  = 8'hCB;
    localparam logic [7:0] CMD_GO_ENTRY1  = 8'hCC;

    localparam logic [31:0] ENTRY1_OFFSET = 32'd8;
    localparam logic [7:0]  ENTRY1_INDEX  = 8'd1;

    localparam logic [3:0] CNT_OFFSET_FIRST = 4'd1;
    localparam logic [3:0] CNT_OFFSET_LAST  = 4'd4;
    localparam logic [3:0] CNT_SIZE_FIRST   = 4'd5;
    localparam logic [3:0] CNT_SIZE_LAST    = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT    = 3'd0,
        REG_ENTRY_LENGTH_0 = 3'd1,
        REG_ENTRY_LENGTH_1 = 3'd2,
        REG_ENTRY_LENGTH_2 = 3'd3,
        REG_ENTRY_LENGTH_3 = 3'd4,
        REG_LOADER_LENGTH  = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_SEND_LOADER = 2'd0,
        ACT_SEND_ENTRY1 = 2'd1,
        ACT_READ_OK     = 2'd2,
        ACT_ERROR       = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_ARM_LOADER = 3'd1,
        MODE_ARM_ENTRY1 = 3'd2,
        MODE_PREFIX     = 3'd3,
        MODE_REQUEST    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
    } cmd_beat_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  entry_index;
        logic [31:0] read_offset_out;
        logic [31:0] read_length;
    } result_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  wr_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } cfg_beat_t;

    typedef struct packed {
        logic [2:0]                    entry_count;
        logic [NUM_LEN_REGS-1:0][31:0] entry_length;
        logic [31:0]                   loader_length;
    } cfg_t;

endpackage

// File: hdl/bcbd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying a payload beat under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcbd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: hdl/bcbd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot command byte decoder configuration registers
// Holds the entry count and the length registers written over the cfg channel.
// ----------------------------------------------------------------------------
module bcbd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    bcbd_stream_if.sink   cfg,
    output bcbd_pkg::cfg_t regs
);
    import bcbd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg.data.wr_index)
                REG_ENTRY_COUNT:    cfg_next.entry_count      = cfg.data.wr_data[2:0];
                REG_ENTRY_LENGTH_0: cfg_next.entry_length[0]  = cfg.data.wr_data;
                REG_ENTRY_LENGTH_1: cfg_next.entry_length[1]  = cfg.data.wr_data;
                REG_ENTRY_LENGTH_2: cfg_next.entry_length[2]  = cfg.data.wr_data;
                REG_ENTRY_LENGTH_3: cfg_next.entry_length[3]  = cfg.data.wr_data;
                REG_LOADER_LENGTH:  cfg_next.loader_length    = cfg.data.wr_data;
                default:            cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/boot_command_byte_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot command byte decoder
// Follows the boot command byte protocol and issues send, read and error beats.
//
//   channel  role  beat                                  when accepted
//   cmd      sink  byte_in                               valid && ready
//   result   src   action, entry_index, offset, length   valid && ready
//   cfg      sink  wr_index, wr_data                     valid (ready held high)
//
// One command byte is taken every cycle while cmd ready is high; its result,
// if any, is registered into the output buffer. The two-entry buffer keeps
// cmd ready while one result waits; cmd ready drops only when both are full.
// Reset clears mode, counter, request fields, cfg and buffer valid flags.
// ----------------------------------------------------------------------------
module boot_command_byte_decoder (
    input  logic          clk,
    input  logic          rst_n,
    bcbd_stream_if.sink   cmd,
    bcbd_stream_if.source result,
    bcbd_stream_if.sink   cfg
);
    import bcbd_pkg::*;

    cfg_t         regs;
    mode_t        mode_reg;
    mode_t        mode_next;
    logic [3:0]   count_reg;
    logic [3:0]   count_next;
    logic [31:0]  offset_reg;
    logic [31:0]  offset_next;
    logic [31:0]  size_reg;
    logic [31:0]  size_next;

    result_beat_t res;
    logic         res_valid;
    logic         accept;
    logic [7:0]   b;
    logic [3:0]   count_inc;
    logic [4:0]   lane_sh;
    logic         index_ok;

    result_beat_t main_reg;
    result_beat_t skid_reg;
    logic         main_valid_reg;
    logic         skid_valid_reg;
    logic         pop;
    logic         push;

    bcbd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign cmd.ready    = !skid_valid_reg;
    assign accept       = cmd.valid && !skid_valid_reg;
    assign b            = cmd.data.byte_in;
    assign count_inc    = count_reg + 4'd1;

    assign index_ok = ({5'd0, regs.entry_count} > b)
        && (b < 8'(MAX_ENTRIES))
        && (b < 8'(NUM_LEN_REGS))
        && (regs.entry_length[b[LEN_IDX_W-1:0]] > offset_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        size_next   = size_reg;
        res_valid   = 1'b0;
        res         = '0;
        lane_sh     = '0;
        case (mode_reg)
            MODE_ARM_LOADER:
            begin
                mode_next = MODE_IDLE;
                if (b == CMD_GO_LOADER)
                begin
                    res_valid       = 1'b1;
                    res.action      = ACT_SEND_LOADER;
                    res.read_length = regs.loader_length;
                end
            end
            MODE_ARM_ENTRY1:
            begin
                mode_next = MODE_IDLE;
                if (b == CMD_GO_ENTRY1)
                begin
                    res_valid           = 1'b1;
                    res.action          = ACT_SEND_ENTRY1;
                    res.entry_index     = ENTRY1_INDEX;
                    res.read_offset_out = ENTRY1_OFFSET;
                    res.read_length     = regs.entry_length[1];
                end
            end
            MODE_PREFIX:
            begin
                mode_next  = (b == CMD_REQUEST) ? MODE_REQUEST : MODE_IDLE;
                count_next = '0;
            end
            MODE_REQUEST:
            begin
                count_next = count_inc;
                if (count_inc inside {[CNT_OFFSET_FIRST:CNT_OFFSET_LAST]})
                begin
                    lane_sh = {count_inc[1:0] - 2'd1, 3'd0};
                    if (count_inc == CNT_OFFSET_FIRST)
                        offset_next = {24'd0, b};
                    else
                        offset_next = offset_reg | ({24'd0, b} << lane_sh);
                end
                else if (count_inc inside {[CNT_SIZE_FIRST:CNT_SIZE_LAST]})
                begin
                    lane_sh = {count_inc[1:0] - 2'd1, 3'd0};
                    if (count_inc == CNT_SIZE_FIRST)
                        size_next = {24'd0, b};
                    else
                        size_next = size_reg | ({24'd0, b} << lane_sh);
                end
                else
                begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    res_valid  = 1'b1;
                    if (index_ok)
                    begin
                        res.action          = ACT_READ_OK;
                        res.entry_index     = b;
                        res.read_offset_out = offset_reg;
                        res.read_length     = size_reg;
                    end
                    else
                    begin
                        res.action = ACT_ERROR;
                    end
                end
            end
            default:
            begin
                case (b)
                    CMD_ARM_LOADER: mode_next = MODE_ARM_LOADER;
                    CMD_ARM_ENTRY1: mode_next = MODE_ARM_ENTRY1;
                    CMD_PREFIX:     mode_next = MODE_PREFIX;
                    default:        mode_next = MODE_IDLE;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            offset_reg <= '0;
            size_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            size_reg   <= size_next;
        end
    end

    // The skid entry fills only when the main entry is held by a stall.
    assign pop  = main_valid_reg && result.ready;
    assign push = accept && res_valid;

    assign result.valid = main_valid_reg;
    assign result.data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

endmodule
